// File: rtl/core/tronu_pkg.sv
package tronu_pkg;

    // Telnet command and character codes.
    localparam logic [7:0] T_IAC  = 8'd255;
    localparam logic [7:0] T_DONT = 8'd254;
    localparam logic [7:0] T_DO   = 8'd253;
    localparam logic [7:0] T_WONT = 8'd252;
    localparam logic [7:0] T_WILL = 8'd251;
    localparam logic [7:0] T_SB   = 8'd250;
    localparam logic [7:0] T_AYT  = 8'd246;
    localparam logic [7:0] T_NOP  = 8'd241;
    localparam logic [7:0] T_CR   = 8'd13;
    localparam logic [7:0] T_LF   = 8'd10;
    localparam logic [7:0] T_NUL  = 8'd0;

    // Option flags after reset: echo and suppress-go-ahead locally, SGA remotely.
    localparam logic [3:0] LOCAL_OPTS_RESET  = 4'b1010;
    localparam logic [3:0] REMOTE_OPTS_RESET = 4'b1000;

    localparam int SUBNEG_MAX_BYTES_DEFAULT = 128;

    // Depth of the queue between the parser and the result sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Destination of one result.
    localparam logic DEST_APP  = 1'b0;
    localparam logic DEST_PEER = 1'b1;

    typedef enum logic [2:0] {
        PS_DATA,
        PS_IAC,
        PS_WILL,
        PS_WONT,
        PS_DO,
        PS_DONT,
        PS_SB,
        PS_SBIAC
    } parse_state_t;

    // Kind of work that one queue entry carries.
    typedef enum logic [1:0] {
        ENT_DATA,
        ENT_AYT,
        ENT_REPLY
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [7:0]  cmd;
        logic [7:0]  data;
    } entry_t;

    // Flag of an option; options above three have no flag.
    function automatic logic opt_flag(input logic [3:0] flags, input logic [7:0] opt);
        return (opt[7:2] == 6'd0) ? flags[opt[1:0]] : 1'b0;
    endfunction

    // Options whose state is tracked: binary, echo and suppress-go-ahead.
    function automatic logic kept_option(input logic [7:0] opt);
        return (opt == 8'd0) || (opt == 8'd1) || (opt == 8'd3);
    endfunction

    function automatic logic [3:0] opt_mask(input logic [7:0] opt);
        return 4'b0001 << opt[1:0];
    endfunction

endpackage

// File: rtl/core/tronu_front.sv
module tronu_front
    import tronu_pkg::*;
#(
    parameter int SUBNEG_MAX_BYTES = SUBNEG_MAX_BYTES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    localparam int CW = $clog2(SUBNEG_MAX_BYTES + 1);

    parse_state_t   state_reg, state_next;
    logic           cr_reg, cr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  count_inc;
    logic [3:0]     local_reg, local_next;
    logic [3:0]     remote_reg, remote_next;
    logic           push;
    logic           accept;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign q_push    = accept && push;
    assign count_inc = count_reg + 1'b1;

    // Parser state registers, updated on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= PS_DATA;
            cr_reg     <= 1'b0;
            count_reg  <= '0;
            local_reg  <= LOCAL_OPTS_RESET;
            remote_reg <= REMOTE_OPTS_RESET;
        end else if (accept) begin
            state_reg  <= state_next;
            cr_reg     <= cr_next;
            count_reg  <= count_next;
            local_reg  <= local_next;
            remote_reg <= remote_next;
        end
    end

    // Classify the byte and decide what work it leaves for the back end.
    always_comb begin
        state_next    = state_reg;
        cr_next       = 1'b0;
        count_next    = count_reg;
        local_next    = local_reg;
        remote_next   = remote_reg;
        push          = 1'b0;
        q_entry.kind  = ENT_DATA;
        q_entry.cmd   = T_IAC;
        q_entry.data  = in_byte;
        unique case (state_reg)
            PS_DATA: begin
                if (cr_reg && (in_byte == T_NUL || in_byte == T_LF)) begin
                    push = 1'b0;
                end else if (in_byte == T_IAC) begin
                    state_next = PS_IAC;
                end else begin
                    push = 1'b1;
                    if (in_byte == T_CR) begin
                        cr_next      = 1'b1;
                        q_entry.data = T_LF;
                    end
                end
            end
            PS_IAC: begin
                state_next = PS_DATA;
                priority if (in_byte == T_IAC) begin
                    push = 1'b1;
                end else if (in_byte == T_AYT) begin
                    push         = 1'b1;
                    q_entry.kind = ENT_AYT;
                end else if (in_byte == T_WILL) begin
                    state_next = PS_WILL;
                end else if (in_byte == T_WONT) begin
                    state_next = PS_WONT;
                end else if (in_byte == T_DO) begin
                    state_next = PS_DO;
                end else if (in_byte == T_DONT) begin
                    state_next = PS_DONT;
                end else if (in_byte == T_SB) begin
                    state_next = PS_SB;
                    count_next = '0;
                end else begin
                    state_next = PS_DATA;
                end
            end
            PS_WILL: begin
                state_next   = PS_DATA;
                q_entry.kind = ENT_REPLY;
                if (!opt_flag(remote_reg, in_byte)) begin
                    push = 1'b1;
                    if (kept_option(in_byte)) begin
                        remote_next = remote_reg | opt_mask(in_byte);
                        q_entry.cmd = T_DO;
                    end else begin
                        q_entry.cmd = T_DONT;
                    end
                end
            end
            PS_WONT: begin
                state_next   = PS_DATA;
                q_entry.kind = ENT_REPLY;
                q_entry.cmd  = T_DONT;
                if (opt_flag(remote_reg, in_byte)) begin
                    push        = 1'b1;
                    remote_next = remote_reg & ~opt_mask(in_byte);
                end
            end
            PS_DO: begin
                state_next   = PS_DATA;
                q_entry.kind = ENT_REPLY;
                if (!opt_flag(local_reg, in_byte)) begin
                    push = 1'b1;
                    if (kept_option(in_byte)) begin
                        local_next  = local_reg | opt_mask(in_byte);
                        q_entry.cmd = T_WILL;
                    end else begin
                        q_entry.cmd = T_WONT;
                    end
                end
            end
            PS_DONT: begin
                state_next   = PS_DATA;
                q_entry.kind = ENT_REPLY;
                q_entry.cmd  = T_WONT;
                if (opt_flag(local_reg, in_byte)) begin
                    push       = 1'b1;
                    local_next = local_reg & ~opt_mask(in_byte);
                end
            end
            PS_SB: begin
                if (in_byte == T_IAC) begin
                    state_next = PS_SBIAC;
                end else if (count_inc >= CW'(SUBNEG_MAX_BYTES)) begin
                    state_next = PS_DATA;
                    count_next = '0;
                end else begin
                    count_next = count_inc;
                end
            end
            PS_SBIAC: begin
                state_next = PS_DATA;
                count_next = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/tronu_queue.sv
module tronu_queue
    import tronu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    entry_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [NW-1:0]  fill_reg;
    logic           do_pop;

    assign full       = (fill_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (!push && do_pop) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/tronu_back.sv
module tronu_back
    import tronu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_dest,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic       valid_reg;
    logic       dest_reg, dest_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg;
    logic       load;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign pop       = load && last_next;
    assign out_valid = valid_reg;
    assign out_dest  = dest_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    // Pick the result byte for the current position within the entry.
    always_comb begin
        dest_next = DEST_PEER;
        byte_next = T_IAC;
        last_next = 1'b0;
        unique case (head_entry.kind)
            ENT_DATA: begin
                dest_next = DEST_APP;
                byte_next = head_entry.data;
                last_next = 1'b1;
            end
            ENT_AYT: begin
                if (idx_reg != 2'd0) begin
                    byte_next = T_NOP;
                    last_next = 1'b1;
                end
            end
            ENT_REPLY: begin
                if (idx_reg == 2'd1) begin
                    byte_next = head_entry.cmd;
                end else if (idx_reg == 2'd2) begin
                    byte_next = head_entry.data;
                    last_next = 1'b1;
                end
            end
            default: begin
                last_next = 1'b1;
            end
        endcase
    end

    // Output register and position counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= last_next ? 2'd0 : idx_reg + 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dest_reg <= dest_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

endmodule

// File: rtl/core/telnet_receive_option_negotiator_unit.sv
// Telnet receive-side option negotiator.
//
// Input channel (s_valid, s_ready, s_rx_byte) takes one received byte per
// transfer. Result channel (m_valid, m_ready, m_destination, m_out_byte,
// m_last) gives zero to three results per input byte: data bytes for the
// application (destination 0) or reply bytes for the peer (destination 1).
// m_last marks the final result of one input byte.
//
// A parser accepts one byte per cycle while the queue is not full and writes
// the work it leaves into a four-entry queue; a sequencer expands each entry
// into its results, one per cycle while the receiver is ready, through the
// output register. The first result of a byte is registered first in the
// queue, behind any earlier entries, and then in the output register. A data
// byte gives one result, and a three-byte reply gives three on the output.
//
// Reset clears the parser to the data state with echo and suppress-go-ahead
// set locally and suppress-go-ahead set remotely, and empties the queue.
// When the receiver stalls, the output holds, the queue fills, and s_ready
// drops once it is full.
module telnet_receive_option_negotiator_unit
    import tronu_pkg::*;
#(
    parameter int SUBNEG_MAX_BYTES = SUBNEG_MAX_BYTES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_destination,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic   q_full;
    logic   q_push;
    entry_t q_entry;
    logic   q_pop;
    logic   head_valid;
    entry_t head_entry;

    // Byte parser and option state.
    tronu_front #(
        .SUBNEG_MAX_BYTES(SUBNEG_MAX_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_valid),
        .in_ready(s_ready),
        .in_byte (s_rx_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // Work queue between parser and sequencer.
    tronu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    // Result sequencer and output register.
    tronu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_entry(head_entry),
        .pop       (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_dest  (m_destination),
        .out_byte  (m_out_byte),
        .out_last  (m_last)
    );

endmodule

// File: rtl/core/tronu_checker.sv
module tronu_checker
    import tronu_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_destination,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_destination) && $stable(m_last))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every data byte for the application is a result on its own.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_destination == DEST_APP) |-> m_last)
        else $error("data result not marked last");

    // A reply burst is not interleaved with data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_destination == DEST_PEER) && !m_last
            |=> !m_valid || (m_destination == DEST_PEER))
        else $error("reply burst broken");

    // Leading reply bytes are IAC or a negotiation command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_destination == DEST_PEER) && !m_last |->
            (m_out_byte == T_IAC) || (m_out_byte == T_DONT) || (m_out_byte == T_DO)
            || (m_out_byte == T_WONT) || (m_out_byte == T_WILL))
        else $error("unexpected leading reply byte");

endmodule

bind telnet_receive_option_negotiator_unit tronu_checker u_tronu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_destination(m_destination),
    .m_out_byte   (m_out_byte),
    .m_last       (m_last)
);
